### rtl/first_fit_heap_allocator_defines.svh
// assertion macros for the first-fit heap allocator
// expects clk and rst_n in the scope of use
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFHA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FFHA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ffha_pkg.sv
// shared types, constants and helper functions of the heap allocator
// no dependencies
package ffha_pkg;

    localparam int POOL_DEPTH         = 4096;
    localparam int IDX_W              = 12;
    localparam int LINK_W             = 13;
    localparam int SIZE_W             = 13;
    localparam int CNT_W              = 12;
    localparam int GRANULE_BYTES      = 16;
    localparam int GRAN_SHIFT         = 4;
    localparam int HEADER_GRANULES    = 1;
    localparam int FOOTER_GRANULES    = 1;
    localparam int TAG_GRANULES       = HEADER_GRANULES + FOOTER_GRANULES;
    localparam int MIN_SPLIT_GRANULES = 3;
    localparam int SPLIT_FLOOR        = (MIN_SPLIT_GRANULES > TAG_GRANULES + 1) ?
                                        MIN_SPLIT_GRANULES : TAG_GRANULES + 1;
    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(POOL_DEPTH);

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_REINIT = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_SIZE = 2'd1;
    localparam logic [1:0] ST_NO_FIT    = 2'd2;
    localparam logic [1:0] ST_BAD_FREE  = 2'd3;

    localparam logic CFG_POOL_BASE     = 1'b0;
    localparam logic CFG_POOL_GRANULES = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] request_bytes;
        logic [31:0] payload_address;
    } in_item_t;

    typedef struct packed {
        logic [31:0] granted_address;
        logic [1:0]  status;
        logic [15:0] free_bytes;
    } out_item_t;

    typedef struct packed {
        logic              valid;
        out_item_t         item;
    } res_t;

    // block head entry, one per granule
    typedef struct packed {
        logic              mark;
        logic              used;
        logic [SIZE_W-1:0] size;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] next;
    } head_entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        head_entry_t       wr_data;
        logic [IDX_W-1:0]  rd_addr;
    } head_port_t;

    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [SIZE_W-1:0] wr_data;
        logic [IDX_W-1:0]  rd_addr;
    } tail_port_t;

    function automatic logic [SIZE_W-1:0] sat_granules(input logic [SIZE_W-1:0] pg);
        logic [SIZE_W-1:0] g;
        g = pg;
        if (g > SIZE_W'(POOL_DEPTH))
            g = SIZE_W'(POOL_DEPTH);
        if (g < SIZE_W'(SPLIT_FLOOR))
            g = SIZE_W'(SPLIT_FLOOR);
        return g;
    endfunction

    function automatic logic [15:0] calc_free_bytes(input logic [SIZE_W-1:0] fsum,
                                                    input logic [CNT_W-1:0] fcount);
        logic [SIZE_W+1:0] over;
        logic [SIZE_W-1:0] g;
        logic [SIZE_W+GRAN_SHIFT-1:0] bytes;
        over  = (SIZE_W+2)'(fcount) * (SIZE_W+2)'(TAG_GRANULES);
        g     = ((SIZE_W+2)'(fsum) > over) ? SIZE_W'((SIZE_W+2)'(fsum) - over) : '0;
        bytes = (SIZE_W+GRAN_SHIFT)'(g) << GRAN_SHIFT;
        return (bytes > (SIZE_W+GRAN_SHIFT)'(16'hFFFF)) ? 16'hFFFF : bytes[15:0];
    endfunction

endpackage

### rtl/ffha_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/ffha_ctrl.sv
// sequencer of the heap allocator: list walk, split, merge and pool clearing
// depends on ffha_pkg; drives the head and tail tag rams
module ffha_ctrl import ffha_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_data,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_wdata,
    output head_port_t        head_port,
    input  head_entry_t       head_rdata,
    output tail_port_t        tail_port,
    input  logic [SIZE_W-1:0] tail_rdata,
    output res_t              res,
    input  logic              res_take
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_CLR      = 5'd1;
    localparam logic [4:0] S_CLR_TAIL = 5'd2;
    localparam logic [4:0] S_A_CHK    = 5'd3;
    localparam logic [4:0] S_A_EVAL   = 5'd4;
    localparam logic [4:0] S_A_WHOLE  = 5'd5;
    localparam logic [4:0] S_A_SPLIT0 = 5'd6;
    localparam logic [4:0] S_A_SPLIT1 = 5'd7;
    localparam logic [4:0] S_LK_P     = 5'd8;
    localparam logic [4:0] S_LK_PW    = 5'd9;
    localparam logic [4:0] S_LK_N     = 5'd10;
    localparam logic [4:0] S_LK_NW    = 5'd11;
    localparam logic [4:0] S_F_RD     = 5'd12;
    localparam logic [4:0] S_F_CHK    = 5'd13;
    localparam logic [4:0] S_F_NRD    = 5'd14;
    localparam logic [4:0] S_F_NCHK   = 5'd15;
    localparam logic [4:0] S_F_BACK   = 5'd16;
    localparam logic [4:0] S_F_TCHK   = 5'd17;
    localparam logic [4:0] S_F_PRD    = 5'd18;
    localparam logic [4:0] S_F_PCHK   = 5'd19;
    localparam logic [4:0] S_F_BFIN   = 5'd20;
    localparam logic [4:0] S_F_PUSH   = 5'd21;
    localparam logic [4:0] S_DONE     = 5'd22;

    localparam int OFF_GW = 32 - GRAN_SHIFT;

    logic [4:0]        state_reg, state_next;
    logic [IDX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic              reinit_reg, reinit_next;
    logic [SIZE_W-1:0] gran_reg, gran_next;
    logic [LINK_W-1:0] list_head_reg, list_head_next;
    logic [SIZE_W-1:0] fsum_reg, fsum_next;
    logic [CNT_W-1:0]  fcount_reg, fcount_next;
    logic [31:0]       pool_base_reg, pool_base_next;
    logic [SIZE_W-1:0] pool_gran_reg, pool_gran_next;
    logic [SIZE_W-1:0] need_reg, need_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] aux_reg, aux_next;
    logic [CNT_W-1:0]  walk_reg, walk_next;
    head_entry_t       ent_reg, ent_next;
    logic [LINK_W-1:0] lk_p_reg, lk_p_next;
    logic [LINK_W-1:0] lk_n_reg, lk_n_next;
    logic [LINK_W-1:0] lk_pval_reg, lk_pval_next;
    logic [LINK_W-1:0] lk_nval_reg, lk_nval_next;
    logic [4:0]        lk_ret_reg, lk_ret_next;
    logic [31:0]       res_addr_reg, res_addr_next;
    logic [1:0]        res_status_reg, res_status_next;

    logic [31:0]       in_off;
    logic [OFF_GW-1:0] in_gran;
    logic [OFF_GW-1:0] in_blk;
    logic [SIZE_W-1:0] in_need;
    logic [SIZE_W-1:0] rest_split;
    logic [IDX_W-1:0]  nb_idx;
    logic [SIZE_W-1:0] merged;
    logic [SIZE_W:0]   fwd_end;
    logic [SIZE_W-1:0] init_size;

    assign in_off     = in_data.payload_address - pool_base_reg;
    assign in_gran    = in_off[31:GRAN_SHIFT];
    assign in_blk     = in_gran - OFF_GW'(HEADER_GRANULES);
    assign in_need    = SIZE_W'(TAG_GRANULES)
                      + SIZE_W'((17'(in_data.request_bytes) + 17'(GRANULE_BYTES - 1))
                                >> GRAN_SHIFT);
    assign rest_split = ent_reg.size - need_reg;
    assign nb_idx     = IDX_W'(cur_reg + need_reg);
    assign merged     = ent_reg.size + head_rdata.size;
    assign fwd_end    = (SIZE_W+1)'(cur_reg) + (SIZE_W+1)'(head_rdata.size);
    assign init_size  = gran_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        res.valid                = (state_reg == S_DONE);
        res.item.granted_address = res_addr_reg;
        res.item.status          = res_status_reg;
        res.item.free_bytes      = calc_free_bytes(fsum_reg, fcount_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        reinit_next     = reinit_reg;
        gran_next       = gran_reg;
        list_head_next  = list_head_reg;
        fsum_next       = fsum_reg;
        fcount_next     = fcount_reg;
        pool_base_next  = pool_base_reg;
        pool_gran_next  = pool_gran_reg;
        need_next       = need_reg;
        cur_next        = cur_reg;
        aux_next        = aux_reg;
        walk_next       = walk_reg;
        ent_next        = ent_reg;
        lk_p_next       = lk_p_reg;
        lk_n_next       = lk_n_reg;
        lk_pval_next    = lk_pval_reg;
        lk_nval_next    = lk_nval_reg;
        lk_ret_next     = lk_ret_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;

        head_port         = '0;
        head_port.rd_addr = cur_reg[IDX_W-1:0];
        tail_port         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_addr_next   = '0;
                    res_status_next = ST_OK;
                    case (in_data.mode)
                        MODE_ALLOC:
                        begin
                            if (in_data.request_bytes == '0)
                            begin
                                res_status_next = ST_ZERO_SIZE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                need_next  = in_need;
                                cur_next   = list_head_reg;
                                walk_next  = '0;
                                state_next = S_A_CHK;
                            end
                        end
                        MODE_FREE:
                        begin
                            if (in_off[GRAN_SHIFT-1:0] != '0 ||
                                in_gran < OFF_GW'(HEADER_GRANULES) ||
                                (in_blk >> IDX_W) != '0)
                            begin
                                res_status_next = ST_BAD_FREE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                cur_next   = LINK_W'(in_blk[IDX_W-1:0]);
                                state_next = S_F_RD;
                            end
                        end
                        MODE_REINIT:
                        begin
                            gran_next      = sat_granules(pool_gran_reg);
                            fsum_next      = sat_granules(pool_gran_reg);
                            list_head_next = '0;
                            fcount_next    = CNT_W'(1);
                            clr_cnt_next   = '0;
                            reinit_next    = 1'b1;
                            state_next     = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // clearing pass, granule zero gets the whole pool
            S_CLR:
            begin
                head_port.wr_en   = 1'b1;
                head_port.wr_addr = clr_cnt_reg;
                if (clr_cnt_reg == '0)
                begin
                    head_port.wr_data.mark = 1'b1;
                    head_port.wr_data.size = init_size;
                    head_port.wr_data.prev = LINK_END;
                    head_port.wr_data.next = LINK_END;
                end
                if (clr_cnt_reg == IDX_W'(POOL_DEPTH - 1))
                begin
                    state_next = S_CLR_TAIL;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                end
            end

            S_CLR_TAIL:
            begin
                tail_port.wr_en   = 1'b1;
                tail_port.wr_addr = IDX_W'(gran_reg - SIZE_W'(1));
                tail_port.wr_data = gran_reg;
                reinit_next       = 1'b0;
                state_next        = reinit_reg ? S_DONE : S_IDLE;
            end

            S_A_CHK:
            begin
                if (walk_reg < fcount_reg && cur_reg < LINK_END)
                begin
                    head_port.rd_addr = cur_reg[IDX_W-1:0];
                    state_next        = S_A_EVAL;
                end
                else
                begin
                    res_status_next = ST_NO_FIT;
                    state_next      = S_DONE;
                end
            end

            S_A_EVAL:
            begin
                if (head_rdata.size >= need_reg)
                begin
                    ent_next      = head_rdata;
                    res_addr_next = pool_base_reg
                                  + ((32'(cur_reg) + 32'(HEADER_GRANULES)) << GRAN_SHIFT);
                    if (head_rdata.size - need_reg < SIZE_W'(SPLIT_FLOOR))
                        state_next = S_A_WHOLE;
                    else
                        state_next = S_A_SPLIT0;
                end
                else
                begin
                    cur_next   = head_rdata.next;
                    walk_next  = walk_reg + CNT_W'(1);
                    state_next = S_A_CHK;
                end
            end

            S_A_WHOLE:
            begin
                head_port.wr_en        = 1'b1;
                head_port.wr_addr      = cur_reg[IDX_W-1:0];
                head_port.wr_data      = ent_reg;
                head_port.wr_data.used = 1'b1;
                fsum_next              = fsum_reg - ent_reg.size;
                fcount_next            = fcount_reg - CNT_W'(1);
                if (list_head_reg == cur_reg)
                    list_head_next = ent_reg.next;
                lk_p_next    = ent_reg.prev;
                lk_n_next    = ent_reg.next;
                lk_pval_next = ent_reg.next;
                lk_nval_next = ent_reg.prev;
                lk_ret_next  = S_DONE;
                state_next   = S_LK_P;
            end

            S_A_SPLIT0:
            begin
                head_port.wr_en        = 1'b1;
                head_port.wr_addr      = cur_reg[IDX_W-1:0];
                head_port.wr_data      = ent_reg;
                head_port.wr_data.mark = 1'b1;
                head_port.wr_data.used = 1'b1;
                head_port.wr_data.size = need_reg;
                tail_port.wr_en        = 1'b1;
                tail_port.wr_addr      = IDX_W'(cur_reg + need_reg - SIZE_W'(1));
                tail_port.wr_data      = need_reg;
                state_next             = S_A_SPLIT1;
            end

            // remainder takes the block's place in the list
            S_A_SPLIT1:
            begin
                head_port.wr_en        = 1'b1;
                head_port.wr_addr      = nb_idx;
                head_port.wr_data      = ent_reg;
                head_port.wr_data.mark = 1'b1;
                head_port.wr_data.used = 1'b0;
                head_port.wr_data.size = rest_split;
                tail_port.wr_en        = 1'b1;
                tail_port.wr_addr      = IDX_W'(SIZE_W'(nb_idx) + rest_split - SIZE_W'(1));
                tail_port.wr_data      = rest_split;
                fsum_next              = fsum_reg - need_reg;
                if (list_head_reg == cur_reg)
                    list_head_next = LINK_W'(nb_idx);
                lk_p_next    = ent_reg.prev;
                lk_n_next    = ent_reg.next;
                lk_pval_next = LINK_W'(nb_idx);
                lk_nval_next = LINK_W'(nb_idx);
                lk_ret_next  = S_DONE;
                state_next   = S_LK_P;
            end

            // neighbor link fix-up: p.next and n.prev, read then write
            S_LK_P:
            begin
                if (lk_p_reg < LINK_END)
                begin
                    head_port.rd_addr = lk_p_reg[IDX_W-1:0];
                    state_next        = S_LK_PW;
                end
                else
                begin
                    state_next = S_LK_N;
                end
            end

            S_LK_PW:
            begin
                head_port.wr_en        = 1'b1;
                head_port.wr_addr      = lk_p_reg[IDX_W-1:0];
                head_port.wr_data      = head_rdata;
                head_port.wr_data.next = lk_pval_reg;
                state_next             = S_LK_N;
            end

            S_LK_N:
            begin
                if (lk_n_reg < LINK_END)
                begin
                    head_port.rd_addr = lk_n_reg[IDX_W-1:0];
                    state_next        = S_LK_NW;
                end
                else
                begin
                    state_next = lk_ret_reg;
                end
            end

            S_LK_NW:
            begin
                head_port.wr_en        = 1'b1;
                head_port.wr_addr      = lk_n_reg[IDX_W-1:0];
                head_port.wr_data      = head_rdata;
                head_port.wr_data.prev = lk_nval_reg;
                state_next             = lk_ret_reg;
            end

            S_F_RD:
            begin
                head_port.rd_addr = cur_reg[IDX_W-1:0];
                state_next        = S_F_CHK;
            end

            S_F_CHK:
            begin
                if (!head_rdata.mark || !head_rdata.used)
                begin
                    res_status_next = ST_BAD_FREE;
                    state_next      = S_DONE;
                end
                else
                begin
                    ent_next      = head_rdata;
                    ent_next.used = 1'b0;
                    fsum_next     = fsum_reg + head_rdata.size;
                    if (fwd_end < (SIZE_W+1)'(POOL_DEPTH))
                    begin
                        aux_next   = LINK_W'(fwd_end);
                        state_next = S_F_NRD;
                    end
                    else
                    begin
                        state_next = S_F_BACK;
                    end
                end
            end

            S_F_NRD:
            begin
                head_port.rd_addr = aux_reg[IDX_W-1:0];
                state_next        = S_F_NCHK;
            end

            // forward merge with a free successor
            S_F_NCHK:
            begin
                if (head_rdata.mark && !head_rdata.used)
                begin
                    head_port.wr_en        = 1'b1;
                    head_port.wr_addr      = aux_reg[IDX_W-1:0];
                    head_port.wr_data      = head_rdata;
                    head_port.wr_data.mark = 1'b0;
                    ent_next.size          = merged;
                    tail_port.wr_en        = 1'b1;
                    tail_port.wr_addr      = IDX_W'(cur_reg + merged - SIZE_W'(1));
                    tail_port.wr_data      = merged;
                    fcount_next            = fcount_reg - CNT_W'(1);
                    if (list_head_reg == aux_reg)
                        list_head_next = head_rdata.next;
                    lk_p_next    = head_rdata.prev;
                    lk_n_next    = head_rdata.next;
                    lk_pval_next = head_rdata.next;
                    lk_nval_next = head_rdata.prev;
                    lk_ret_next  = S_F_BACK;
                    state_next   = S_LK_P;
                end
                else
                begin
                    state_next = S_F_BACK;
                end
            end

            S_F_BACK:
            begin
                if (cur_reg != '0)
                begin
                    tail_port.rd_addr = IDX_W'(cur_reg - LINK_W'(1));
                    state_next        = S_F_TCHK;
                end
                else
                begin
                    state_next = S_F_PUSH;
                end
            end

            S_F_TCHK:
            begin
                if (tail_rdata != '0 && tail_rdata <= cur_reg)
                begin
                    aux_next   = cur_reg - tail_rdata;
                    state_next = S_F_PRD;
                end
                else
                begin
                    state_next = S_F_PUSH;
                end
            end

            S_F_PRD:
            begin
                head_port.rd_addr = aux_reg[IDX_W-1:0];
                state_next        = S_F_PCHK;
            end

            // backward merge into a free predecessor
            S_F_PCHK:
            begin
                if (head_rdata.mark && !head_rdata.used)
                begin
                    head_port.wr_en        = 1'b1;
                    head_port.wr_addr      = aux_reg[IDX_W-1:0];
                    head_port.wr_data      = head_rdata;
                    head_port.wr_data.size = merged;
                    tail_port.wr_en        = 1'b1;
                    tail_port.wr_addr      = IDX_W'(aux_reg + merged - SIZE_W'(1));
                    tail_port.wr_data      = merged;
                    state_next             = S_F_BFIN;
                end
                else
                begin
                    state_next = S_F_PUSH;
                end
            end

            S_F_BFIN:
            begin
                head_port.wr_en        = 1'b1;
                head_port.wr_addr      = cur_reg[IDX_W-1:0];
                head_port.wr_data      = ent_reg;
                head_port.wr_data.mark = 1'b0;
                state_next             = S_DONE;
            end

            S_F_PUSH:
            begin
                head_port.wr_en        = 1'b1;
                head_port.wr_addr      = cur_reg[IDX_W-1:0];
                head_port.wr_data      = ent_reg;
                head_port.wr_data.prev = LINK_END;
                head_port.wr_data.next = (fcount_reg != '0) ? list_head_reg : LINK_END;
                lk_p_next      = LINK_END;
                lk_n_next      = (fcount_reg != '0) ? list_head_reg : LINK_END;
                lk_nval_next   = cur_reg;
                lk_ret_next    = S_DONE;
                list_head_next = cur_reg;
                fcount_next    = fcount_reg + CNT_W'(1);
                state_next     = S_LK_P;
            end

            S_DONE:
            begin
                if (res_take)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_POOL_BASE:     pool_base_next = cfg_wdata;
                CFG_POOL_GRANULES: pool_gran_next = cfg_wdata[SIZE_W-1:0];
                default:           pool_base_next = pool_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            reinit_reg    <= 1'b0;
            gran_reg      <= SIZE_W'(POOL_DEPTH);
            list_head_reg <= '0;
            fsum_reg      <= SIZE_W'(POOL_DEPTH);
            fcount_reg    <= CNT_W'(1);
            pool_base_reg <= '0;
            pool_gran_reg <= SIZE_W'(POOL_DEPTH);
            lk_ret_reg    <= S_DONE;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            reinit_reg    <= reinit_next;
            gran_reg      <= gran_next;
            list_head_reg <= list_head_next;
            fsum_reg      <= fsum_next;
            fcount_reg    <= fcount_next;
            pool_base_reg <= pool_base_next;
            pool_gran_reg <= pool_gran_next;
            lk_ret_reg    <= lk_ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg       <= need_next;
        cur_reg        <= cur_next;
        aux_reg        <= aux_next;
        walk_reg       <= walk_next;
        ent_reg        <= ent_next;
        lk_p_reg       <= lk_p_next;
        lk_n_reg       <= lk_n_next;
        lk_pval_reg    <= lk_pval_next;
        lk_nval_reg    <= lk_nval_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
    end

endmodule

### rtl/first_fit_heap_allocator.sv
// First-fit boundary-tag heap allocator, top level.
// Input channel (in_valid/in_ready/in_data) takes one request per transaction:
// allocate, free or reinitialize. Output channel (out_valid/out_ready/out_data)
// returns exactly one result per request, in order: granted payload address,
// status and the free payload bytes left in the pool.
// Configuration: cfg_we/cfg_index/cfg_wdata writes pool_base (index 0) or
// pool_granules (index 1); write only while no request is in flight.
// Sequence, accept to result: allocate walks the free list entry by entry
// and tags and relinks the first block that fits, else reports no fit (a
// zero-size request skips the walk); free rejects a misaligned or out-of-range
// address outright, checks the tag, merges with a free successor, then folds
// into a free predecessor or else joins the free list head. Every walk step
// and tag update is one access to the head tag ram.
// One request is in work at a time; a new one is taken once the previous
// result sits in the output register.
// Reset and reinitialize: a clearing pass rebuilds the pool as one free block;
// in_ready stays low during it, configuration writes are still taken.
// A stalled receiver holds the result in the output register; one more
// request may complete up to its result and then waits there.
// depends on ffha_pkg, ffha_ram, ffha_ctrl and the assertion macro header
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator import ffha_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    head_port_t        head_port;
    head_entry_t       head_rdata;
    tail_port_t        tail_port;
    logic [SIZE_W-1:0] tail_rdata;
    res_t              res;
    logic              res_take;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg;

    ffha_ram #(
        .WIDTH ($bits(head_entry_t)),
        .DEPTH (POOL_DEPTH)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_port.wr_en),
        .waddr (head_port.wr_addr),
        .wdata (head_port.wr_data),
        .raddr (head_port.rd_addr),
        .rdata (head_rdata)
    );

    ffha_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (POOL_DEPTH)
    ) u_tail_ram (
        .clk   (clk),
        .we    (tail_port.wr_en),
        .waddr (tail_port.wr_addr),
        .wdata (tail_port.wr_data),
        .raddr (tail_port.rd_addr),
        .rdata (tail_rdata)
    );

    ffha_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .head_port  (head_port),
        .head_rdata (head_rdata),
        .tail_port  (tail_port),
        .tail_rdata (tail_rdata),
        .res        (res),
        .res_take   (res_take)
    );

    // output register decouples the sequencer from the receiver
    assign res_take = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.valid && res_take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_take)
            out_data_reg <= res.item;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `FFHA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "sequencer took a second transaction")
    `FFHA_ASSERT_NOW(a_idle_no_result, in_ready, !res.valid, "result pending while idle")
    `FFHA_ASSERT_NOW(a_fail_zero_addr, out_valid && (out_data.status != ST_OK), out_data.granted_address == 32'd0, "failed request carries an address")

endmodule

### tb/tb_top.sv
// self-checking testbench for the first-fit heap allocator
// holds its own model of the pool tables and compares every result transaction
// depends on ffha_pkg and first_fit_heap_allocator
`timescale 1ns / 100ps

module tb_top;
    import ffha_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int SETTLE_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;

    first_fit_heap_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // model of the pool
    logic [31:0]       pool_base_q;
    logic [12:0]       pool_gran_q;
    bit                tag_mark [POOL_DEPTH];
    bit                tag_used [POOL_DEPTH];
    logic [SIZE_W-1:0] tag_size [POOL_DEPTH];
    logic [SIZE_W-1:0] foot_size [POOL_DEPTH];
    logic [LINK_W-1:0] link_bwd [POOL_DEPTH];
    logic [LINK_W-1:0] link_fwd [POOL_DEPTH];
    logic [LINK_W-1:0] free_head;
    logic [SIZE_W-1:0] free_gran;
    logic [CNT_W-1:0]  free_cnt;

    out_item_t         expected_q[$];
    logic [31:0]       live_addr[$];
    logic [31:0]       last_freed;

    int  errors = 0;
    int  cycles = 0;
    int  hold_off = 0;
    bit  calm = 0;
    int  n_items = 0, n_alloc = 0, n_free = 0, n_bad = 0, n_nofit = 0, n_reinit = 0;

    function automatic int unsigned wrap_idx(input int unsigned x);
        return x % POOL_DEPTH;
    endfunction

    function automatic void pool_rebuild();
        int unsigned g;
        g = 32'(pool_gran_q);
        if (g > POOL_DEPTH) g = POOL_DEPTH;
        if (g < SPLIT_FLOOR) g = SPLIT_FLOOR;
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            tag_mark[i] = 1'b0; tag_used[i] = 1'b0; tag_size[i] = '0;
            foot_size[i] = '0; link_bwd[i] = '0; link_fwd[i] = '0;
        end
        tag_mark[0] = 1'b1;
        tag_size[0] = SIZE_W'(g);
        foot_size[wrap_idx(g - 1)] = SIZE_W'(g);
        link_bwd[0] = LINK_END;
        link_fwd[0] = LINK_END;
        free_head = '0;
        free_gran = SIZE_W'(g);
        free_cnt = CNT_W'(1);
    endfunction

    function automatic void list_unlink(input int unsigned x);
        logic [LINK_W-1:0] p, n;
        p = link_bwd[wrap_idx(x)];
        n = link_fwd[wrap_idx(x)];
        if (p < LINK_END) link_fwd[p] = n;
        if (n < LINK_END) link_bwd[n] = p;
        if (free_head == x) free_head = n;
    endfunction

    function automatic void list_swap(input int unsigned x, input int unsigned y);
        logic [LINK_W-1:0] p, n;
        p = link_bwd[wrap_idx(x)];
        n = link_fwd[wrap_idx(x)];
        link_bwd[wrap_idx(y)] = p;
        link_fwd[wrap_idx(y)] = n;
        if (p < LINK_END) link_fwd[p] = LINK_W'(y);
        if (n < LINK_END) link_bwd[n] = LINK_W'(y);
        if (free_head == x) free_head = LINK_W'(y);
    endfunction

    function automatic logic [15:0] payload_left();
        int unsigned over, g, bytes;
        over = 32'(free_cnt) * TAG_GRANULES;
        g = (32'(free_gran) > over) ? 32'(free_gran) - over : 0;
        bytes = g * GRANULE_BYTES;
        return (bytes > 65535) ? 16'hFFFF : bytes[15:0];
    endfunction

    function automatic void heap_alloc(input logic [15:0] req, output logic [31:0] addr,
                                       output logic [1:0] st);
        int unsigned need, cur, sz, rest, nb;
        addr = '0;
        st = ST_NO_FIT;
        if (req == 0)
        begin
            st = ST_ZERO_SIZE;
            return;
        end
        need = TAG_GRANULES + (32'(req) + GRANULE_BYTES - 1) / GRANULE_BYTES;
        cur = 32'(free_head);
        for (int i = 0; i < free_cnt && cur < LINK_END; i++)
        begin
            sz = 32'(tag_size[cur]);
            if (sz >= need)
            begin
                rest = sz - need;
                if (rest < SPLIT_FLOOR)
                begin
                    list_unlink(cur);
                    free_gran = SIZE_W'(32'(free_gran) - sz);
                    free_cnt = free_cnt - CNT_W'(1);
                end
                else
                begin
                    nb = wrap_idx(cur + need);
                    tag_size[cur] = SIZE_W'(need);
                    foot_size[wrap_idx(cur + need - 1)] = SIZE_W'(need);
                    tag_mark[nb] = 1'b1;
                    tag_size[nb] = SIZE_W'(rest);
                    tag_used[nb] = 1'b0;
                    foot_size[wrap_idx(nb + rest - 1)] = SIZE_W'(rest);
                    list_swap(cur, nb);
                    free_gran = SIZE_W'(32'(free_gran) - need);
                end
                tag_used[cur] = 1'b1;
                addr = pool_base_q + 32'((cur + HEADER_GRANULES) * GRANULE_BYTES);
                st = ST_OK;
                return;
            end
            cur = 32'(link_fwd[cur]);
        end
    endfunction

    function automatic logic [1:0] heap_free(input logic [31:0] paddr);
        logic [31:0] off;
        int unsigned g, b, sz, n, t, p;
        off = paddr - pool_base_q;
        if (off % GRANULE_BYTES != 0) return ST_BAD_FREE;
        g = off / GRANULE_BYTES;
        if (g < HEADER_GRANULES) return ST_BAD_FREE;
        b = g - HEADER_GRANULES;
        if (b >= POOL_DEPTH || !tag_mark[b] || !tag_used[b]) return ST_BAD_FREE;
        sz = 32'(tag_size[b]);
        tag_used[b] = 1'b0;
        free_gran = SIZE_W'(32'(free_gran) + sz);
        n = b + sz;
        // absorb the following block when it is free
        if (n < POOL_DEPTH && tag_mark[n] && !tag_used[n])
        begin
            list_unlink(n);
            tag_mark[n] = 1'b0;
            sz = sz + 32'(tag_size[n]);
            tag_size[b] = SIZE_W'(sz);
            foot_size[wrap_idx(b + sz - 1)] = SIZE_W'(sz);
            free_cnt = free_cnt - CNT_W'(1);
        end
        // then fold into the preceding block via its footer
        if (b > 0)
        begin
            t = 32'(foot_size[b - 1]);
            if (t >= 1 && t <= b)
            begin
                p = b - t;
                if (tag_mark[p] && !tag_used[p])
                begin
                    tag_size[p] = tag_size[p] + SIZE_W'(sz);
                    foot_size[wrap_idx(p + 32'(tag_size[p]) - 1)] = tag_size[p];
                    tag_mark[b] = 1'b0;
                    return ST_OK;
                end
            end
        end
        link_bwd[b] = LINK_END;
        link_fwd[b] = (free_cnt > 0) ? free_head : LINK_END;
        if (free_cnt > 0 && free_head < LINK_END) link_bwd[free_head] = LINK_W'(b);
        free_head = LINK_W'(b);
        free_cnt = free_cnt + CNT_W'(1);
        return ST_OK;
    endfunction

    function automatic out_item_t heap_step(input in_item_t it);
        out_item_t r;
        r.granted_address = '0;
        r.status = ST_OK;
        case (it.mode)
            MODE_ALLOC:  heap_alloc(it.request_bytes, r.granted_address, r.status);
            MODE_FREE:   r.status = heap_free(it.payload_address);
            MODE_REINIT: pool_rebuild();
            default:     ;
        endcase
        r.free_bytes = payload_left();
        return r;
    endfunction

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stalls plus a long hold-off on request
    int stall_left = 0;
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                out_ready = 0;
            end
            else
            begin
                if (stall_left > 0)
                    stall_left--;
                else if (!calm)
                begin
                    int r;
                    r = $urandom_range(0, 99);
                    if (r < 12) stall_left = $urandom_range(1, 3);
                    else if (r < 14) stall_left = $urandom_range(20, 60);
                end
                out_ready = (stall_left == 0);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transaction %h", $time, out_data);
            end
            else
            begin
                out_item_t e;
                e = expected_q.pop_front();
                if (out_data.granted_address !== e.granted_address)
                begin
                    errors++;
                    $display("%0t: granted_address expected %h actual %h",
                             $time, e.granted_address, out_data.granted_address);
                end
                if (out_data.status !== e.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, e.status, out_data.status);
                end
                if (out_data.free_bytes !== e.free_bytes)
                begin
                    errors++;
                    $display("%0t: free_bytes expected %0d actual %0d",
                             $time, e.free_bytes, out_data.free_bytes);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one request transaction; called and returns at a falling edge
    task automatic send_req(input logic [1:0] mode, input logic [15:0] req,
                            input logic [31:0] paddr);
        in_item_t it;
        out_item_t r;
        int gap;
        it.mode = mode;
        it.request_bytes = req;
        it.payload_address = paddr;
        in_data = it;
        in_valid = 1;
        do @(posedge clk); while (!in_ready);
        r = heap_step(it);
        expected_q.push_back(r);
        n_items++;
        if (mode == MODE_ALLOC && r.status == ST_OK)
        begin
            live_addr.push_back(r.granted_address);
            n_alloc++;
        end
        if (mode == MODE_ALLOC && r.status == ST_NO_FIT) n_nofit++;
        if (mode == MODE_FREE && r.status == ST_OK)
        begin
            n_free++;
            last_freed = paddr;
            foreach (live_addr[i])
                if (live_addr[i] == paddr)
                begin
                    live_addr.delete(i);
                    break;
                end
        end
        if (r.status == ST_BAD_FREE) n_bad++;
        if (mode == MODE_REINIT)
        begin
            live_addr.delete();
            n_reinit++;
        end
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid = 0;
        wait (expected_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_we = 1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 0;
        if (idx == CFG_POOL_BASE) pool_base_q = val;
        else pool_gran_q = val[12:0];
    endtask

    // a new pool base applies at once, a new pool size only through a reinit request
    task automatic set_pool(input logic [31:0] base, input logic [12:0] gran);
        wait_idle();
        write_reg(CFG_POOL_BASE, base);
        write_reg(CFG_POOL_GRANULES, 32'(gran));
        send_req(MODE_REINIT, 16'($urandom), $urandom);
    endtask

    task automatic free_oldest();
        if (live_addr.size() > 0) send_req(MODE_FREE, 16'($urandom), live_addr[0]);
    endtask

    task automatic test_directed();
        logic [31:0] a, b, c;
        send_req(MODE_ALLOC, 16'd0, 32'hFFFF_FFFF);
        send_req(MODE_ALLOC, 16'd1, '0);
        send_req(MODE_ALLOC, 16'd16, '0);
        send_req(MODE_ALLOC, 16'd17, '0);
        send_req(MODE_ALLOC, 16'hFFFF, '0);
        send_req(MODE_FREE, 16'($urandom), pool_base_q + 32'd24);        // misaligned
        send_req(MODE_FREE, 16'($urandom), pool_base_q);                 // ahead of first payload
        send_req(MODE_FREE, 16'($urandom), pool_base_q + 32'd48);        // not a block start
        send_req(MODE_FREE, 16'($urandom), pool_base_q + 32'hFFFF_FFF0); // beyond the pool
        send_req(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
        a = live_addr[0]; b = live_addr[1]; c = live_addr[2];
        send_req(MODE_FREE, 16'($urandom), a);
        send_req(MODE_FREE, 16'($urandom), a);                           // double free
        send_req(MODE_FREE, 16'($urandom), c);
        send_req(MODE_FREE, 16'($urandom), b);                           // merges both ways
        send_req(MODE_REINIT, 16'hFFFF, 32'hFFFF_FFFF);
        send_req(MODE_ALLOC, 16'd65504, '0);                        // whole pool
        send_req(MODE_ALLOC, 16'd1, '0);
        free_oldest();
        send_req(MODE_ALLOC, 16'd65488, '0);                        // rest below the split floor, no split
        send_req(MODE_ALLOC, 16'd1, '0);
        send_req(MODE_ALLOC, 16'd1, '0);
        wait_idle();
    endtask

    task automatic test_pool_limits();
        set_pool(32'h0000_0000, 13'd0);          // below range, floor pool
        send_req(MODE_ALLOC, 16'd1, '0);
        send_req(MODE_ALLOC, 16'd1, '0);
        free_oldest();
        set_pool(32'hFFFF_FFF0, 13'h1FFF);       // above range, base wraps
        send_req(MODE_ALLOC, 16'd40, '0);
        send_req(MODE_ALLOC, 16'd8, '0);
        send_req(MODE_FREE, 16'($urandom), 32'hFFFF_FFF0);
        free_oldest();
        free_oldest();
        set_pool(32'h1234_5677, 13'd3);          // unaligned base
        send_req(MODE_ALLOC, 16'd16, '0);
        send_req(MODE_FREE, 16'($urandom), 32'h1234_5687);
        free_oldest();
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_pool(32'h0001_0000, 13'd64);
        @(negedge clk);
        hold_off = 400;
        calm = 1;
        for (int i = 0; i < 12; i++) send_req(MODE_ALLOC, 16'($urandom_range(1, 40)), '0);
        calm = 0;
        wait_idle();
        for (int i = 0; i < 6; i++) free_oldest();
        wait_idle();
    endtask

    task automatic test_random(input logic [31:0] base, input logic [12:0] gran,
                               input int count);
        int top;
        set_pool(base, gran);
        top = (gran > 13'd1 && gran < 13'd4096) ? 32'(gran) * 4 : 1000;
        if (top < 32) top = 32;
        for (int i = 0; i < count; i++)
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 50)
                send_req(MODE_ALLOC, 16'($urandom_range(1, top)), $urandom);
            else if (r < 54)
                send_req(MODE_ALLOC, 16'($urandom), $urandom);
            else if (r < 56)
                send_req(MODE_ALLOC, 16'd0, $urandom);
            else if (r < 88 && live_addr.size() > 0)
                send_req(MODE_FREE, 16'($urandom),
                         live_addr[$urandom_range(0, live_addr.size() - 1)]);
            else if (r < 91)
                send_req(MODE_FREE, 16'($urandom), last_freed);
            else if (r < 94)
                send_req(MODE_FREE, 16'($urandom), $urandom);
            else if (r < 96 && live_addr.size() > 0)
                send_req(MODE_FREE, 16'($urandom), live_addr[0] + $urandom_range(1, 40));
            else if (r < 98)
                send_req(MODE_UNUSED, 16'($urandom), $urandom);
            else
                send_req(MODE_REINIT, 16'($urandom), $urandom);
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_we = 0;
        cfg_index = CFG_POOL_BASE;
        cfg_wdata = '0;
        pool_base_q = '0;
        pool_gran_q = 13'd4096;
        last_freed = '0;
        pool_rebuild();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        test_directed();
        test_pool_limits();
        test_backpressure();
        test_random(32'($urandom_range(0, 32'h0FFF_FFFF)) << 4, 13'd64, 220);
        test_random('0, 13'd4096, 150);
        test_random($urandom, 13'd200, 160);
        calm = 1;
        test_random(32'hFFFF_FF00, 13'd16, 80);
        calm = 0;
        test_random(32'($urandom_range(0, 32'h0FFF_FFFF)) << 4, 13'd5, 60);

        wait_idle();
        $display("%0d requests: %0d allocations granted, %0d no-fit, %0d frees, %0d rejected",
                 n_items, n_alloc, n_nofit, n_free, n_bad);
        $display("%0d pool rebuilds over several base and size settings", n_reinit);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator.sv
tb/tb_top.sv
